FILE: design/grwc_pkg.sv
// ----------------------------------------------------------------------------
// grwc_pkg: shared types, constants and trig tables
// Q.14 sine table, coordinate saturation and pipeline record types for the
// column ray caster.
// ----------------------------------------------------------------------------
`default_nettype none

package grwc_pkg;

  localparam int PIPE_DEPTH  = 77;   // total register stages, input to output
  localparam int DIV_NW      = 29;   // divider numerator / quotient width
  localparam int DIV_DW      = 18;   // divider denominator width
  localparam int DIV_LAT     = DIV_NW;
  localparam int MARCH_STEPS = 8;

  localparam logic [DIV_NW-1:0] HEIGHT_NUM = 29'd5242880;  // 64*320*256
  localparam logic [17:0] DIST_MAX   = 18'd262143;
  localparam logic [17:0] FULL_LIMIT = 18'd16384;          // height 320 at or below
  localparam logic [8:0]  SCREEN_H   = 9'd320;
  localparam logic [7:0]  SCREEN_MID = 8'd160;

  typedef logic signed [20:0] coord_t;
  typedef logic signed [15:0] trig_t;

  localparam logic [14:0] SIN_QUARTER [0:90] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
    15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
    15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
    15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
    15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  // Side data that rides alongside the intercept dividers
  typedef struct packed {
    logic [16:0] px;
    logic [16:0] py;
    trig_t       s;
    trig_t       c;
    logic [14:0] cc;
    coord_t      rx0;
    coord_t      ry0;
    logic        neg1;
    logic        neg3;
  } side_t;

  typedef struct packed {
    logic [16:0] px;
    logic [16:0] py;
    trig_t       s;
    trig_t       c;
    logic [14:0] cc;
  } pos_t;

  typedef struct packed {
    coord_t rx;
    coord_t ry;
    coord_t xo;
    coord_t yo;
    logic   live;
    logic   hit;
  } march_t;

  typedef struct packed {
    logic [17:0] corr;
    logic        use_v;
    logic        found;
    logic        big;
  } fin_t;

  function automatic trig_t sin_deg(input logic [8:0] a);
    logic [8:0] k;
    logic       neg;
    if (a <= 9'd90) begin
      k = a;
      neg = 1'b0;
    end else if (a <= 9'd180) begin
      k = 9'd180 - a;
      neg = 1'b0;
    end else if (a <= 9'd270) begin
      k = a - 9'd180;
      neg = 1'b1;
    end else begin
      k = 9'd360 - a;
      neg = 1'b1;
    end
    return neg ? -$signed({1'b0, SIN_QUARTER[k[6:0]]})
               : $signed({1'b0, SIN_QUARTER[k[6:0]]});
  endfunction

  function automatic trig_t cos_deg(input logic [8:0] a);
    logic [8:0] b;
    b = (a >= 9'd270) ? (a - 9'd270) : (a + 9'd90);
    return sin_deg(b);
  endfunction

  function automatic coord_t sat_coord(input logic signed [31:0] v);
    if (v > 32'sd1048575) return 21'sd1048575;
    if (v < -32'sd1048575) return -21'sd1048575;
    return v[20:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/grwc_ifs.sv
// ----------------------------------------------------------------------------
// grwc_ifs: item channels
// Ray request channel and wall slice result channel, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface grwc_in_if;
  logic        valid;
  logic        ready;
  logic [16:0] player_x;
  logic [16:0] player_y;
  logic [8:0]  heading;
  logic [5:0]  column;
  modport source (output valid, player_x, player_y, heading, column, input ready);
  modport sink   (input valid, player_x, player_y, heading, column, output ready);
endinterface

interface grwc_out_if;
  logic        valid;
  logic        ready;
  logic [8:0]  wall_height;
  logic [7:0]  wall_top;
  logic        hit_vertical;
  logic        wall_found;
  logic [17:0] corrected_distance;
  modport source (output valid, wall_height, wall_top, hit_vertical, wall_found,
                  corrected_distance, input ready);
  modport sink   (input valid, wall_height, wall_top, hit_vertical, wall_found,
                  corrected_distance, output ready);
endinterface

`default_nettype wire

FILE: design/grwc_div.sv
// ----------------------------------------------------------------------------
// grwc_div: pipelined unsigned divider
// Restoring division, one quotient bit per stage, DIV_NW stages.
// ----------------------------------------------------------------------------
`default_nettype none

module grwc_div (
  input  wire                         clk,
  input  wire                         en,
  input  wire [grwc_pkg::DIV_NW-1:0]  num,
  input  wire [grwc_pkg::DIV_DW-1:0]  den,
  output logic [grwc_pkg::DIV_NW-1:0] quot
);
  import grwc_pkg::*;

  logic [DIV_DW-1:0] rem_r [0:DIV_NW-1];
  logic [DIV_NW-1:0] nq_r  [0:DIV_NW-1];   // numerator bits left, quotient bits in
  logic [DIV_DW-1:0] den_r [0:DIV_NW-1];

  for (genvar i = 0; i < DIV_NW; i++) begin : g_stage
    logic [DIV_DW-1:0] rem_in;
    logic [DIV_NW-1:0] nq_in;
    logic [DIV_DW-1:0] den_in;
    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign nq_in  = nq_r[i-1];
      assign den_in = den_r[i-1];
    end

    assign trial = {rem_in, nq_in[DIV_NW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
        nq_r[i]  <= {nq_in[DIV_NW-2:0], ge};
        den_r[i] <= den_in;
      end
    end
  end

  assign quot = nq_r[DIV_NW-1];

endmodule

`default_nettype wire

FILE: design/grid_ray_wall_column.sv
// ----------------------------------------------------------------------------
// grid_ray_wall_column: one-column grid ray caster
// Casts the ray of one screen column over an 8x8 bit wall map and returns the
// wall slice height, top offset and fisheye-corrected distance.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one item per ray (player x/y in Q.14, heading in degrees, column).
//   out_ch : one item per ray (wall height, top, side hit, found, distance).
//   cfg    : cfg_wr_en/cfg_wr_data load the 64-bit wall map (bit my*8+mx).
//            Write it only while no ray is in flight.
// The pipeline takes one item every cycle while out_ch is not stalled; the
// 29-stage intercept and height dividers and the eight march stages per
// gridline direction set the depth.
// All stages advance together: when out_ch holds a result that is not taken,
// the whole pipeline freezes and in_ch.ready drops; nothing is lost.
// Reset (rst_n low, synchronous) empties the pipeline and clears the map.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_ray_wall_column (
  input  wire         clk,
  input  wire         rst_n,
  grwc_in_if.sink     in_ch,
  grwc_out_if.source  out_ch,
  input  wire         cfg_wr_en,
  input  wire [63:0]  cfg_wr_data
);
  import grwc_pkg::*;

  function automatic logic is_wall(input coord_t x, input coord_t y,
                                   input logic [63:0] map);
    // negative or beyond cell 7 on either axis is open space
    if (x[20] || y[20] || (x[19:17] != 3'd0) || (y[19:17] != 3'd0)) return 1'b0;
    return map[{y[16:14], x[16:14]}];
  endfunction

  function automatic logic [14:0] s2_abs(input trig_t t);
    trig_t m;
    m = t[15] ? -t : t;
    return m[14:0];
  endfunction

  logic [63:0]           wall_map_r;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic                  en;

  assign en          = !vld_r[PIPE_DEPTH-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_map_r <= '0;
      vld_r      <= '0;
    end else begin
      if (cfg_wr_en) wall_map_r <= cfg_wr_data;
      if (en) vld_r <= {vld_r[PIPE_DEPTH-2:0], in_ch.valid};
    end
  end

  // --- S0: capture -----------------------------------------------------------
  logic [16:0] px0_r, py0_r;
  logic [8:0]  pa0_r;
  logic [5:0]  col0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px0_r  <= in_ch.player_x;
      py0_r  <= in_ch.player_y;
      pa0_r  <= in_ch.heading;
      col0_r <= in_ch.column;
    end
  end

  // --- S1: ray angle = (pa + 30 - column) mod 360 -----------------------------
  logic [8:0]  pam;
  logic [9:0]  asum;
  logic [8:0]  ra_nxt;
  logic [16:0] px1_r, py1_r;
  logic [8:0]  ra1_r;
  logic [5:0]  cam1_r;

  always_comb begin
    pam  = (pa0_r >= 9'd360) ? (pa0_r - 9'd360) : pa0_r;
    asum = {1'b0, pam} + 10'd390 - {4'b0000, col0_r};
    if (asum >= 10'd720)      ra_nxt = 9'(asum - 10'd720);
    else if (asum >= 10'd360) ra_nxt = 9'(asum - 10'd360);
    else                      ra_nxt = asum[8:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1_r  <= px0_r;
      py1_r  <= py0_r;
      ra1_r  <= ra_nxt;
      // fisheye angle is column-30; cosine is even
      cam1_r <= (col0_r >= 6'd30) ? (col0_r - 6'd30) : (6'd30 - col0_r);
    end
  end

  // --- S2: trig lookups ------------------------------------------------------
  logic [16:0] px2_r, py2_r;
  trig_t       s2_r, c2_r;
  logic [14:0] cc2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px2_r <= px1_r;
      py2_r <= py1_r;
      s2_r  <= sin_deg(ra1_r);
      c2_r  <= cos_deg(ra1_r);
      cc2_r <= SIN_QUARTER[7'd90 - {1'b0, cam1_r}];
    end
  end

  // --- S3: first gridlines and intercept products ----------------------------
  logic [3:0]          bxp, byp;
  coord_t              rx0, ry0;
  logic signed [20:0]  dx, dy;
  logic signed [36:0]  prod_v, prod_h;
  pos_t                p3_r;
  coord_t              rx0_3_r, ry0_3_r;
  logic signed [36:0]  prod_v3_r, prod_h3_r;

  always_comb begin
    bxp = {1'b0, px2_r[16:14]} + 4'd1;
    byp = {1'b0, py2_r[16:14]} + 4'd1;
    rx0 = (c2_r > 0) ? coord_t'({3'b000, bxp, 14'd0})
                     : coord_t'({4'b0000, px2_r[16:14], 14'd0}) - 21'sd1;
    ry0 = (s2_r > 0) ? coord_t'({4'b0000, py2_r[16:14], 14'd0}) - 21'sd1
                     : coord_t'({3'b000, byp, 14'd0});
    dx  = rx0 - $signed({4'b0000, px2_r});
    dy  = ry0 - $signed({4'b0000, py2_r});
    prod_v = 37'(dx) * 37'(s2_r);
    prod_h = 37'(dy) * 37'(c2_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_r      <= '{px: px2_r, py: py2_r, s: s2_r, c: c2_r, cc: cc2_r};
      rx0_3_r   <= rx0;
      ry0_3_r   <= ry0;
      prod_v3_r <= prod_v;
      prod_h3_r <= prod_h;
    end
  end

  // --- S4: divider operands (magnitudes, truncation toward zero) -------------
  logic [14:0]       abs_s, abs_c;
  logic [36:0]       mag_v, mag_h;
  logic [DIV_NW-1:0] n1_r, n2_r, n3_r, n4_r;
  logic [DIV_DW-1:0] dc_r, ds_r;
  side_t             side4_r;

  always_comb begin
    abs_s = s2_abs(p3_r.s);
    abs_c = s2_abs(p3_r.c);
    mag_v = prod_v3_r[36] ? 37'(-prod_v3_r) : 37'(prod_v3_r);
    mag_h = prod_h3_r[36] ? 37'(-prod_h3_r) : 37'(prod_h3_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r <= mag_v[DIV_NW-1:0];
      n2_r <= {abs_s, 14'd0};
      n3_r <= mag_h[DIV_NW-1:0];
      n4_r <= {abs_c, 14'd0};
      dc_r <= (abs_c == 15'd0) ? DIV_DW'(1) : DIV_DW'(abs_c);  // axis ray: march skipped
      ds_r <= (abs_s == 15'd0) ? DIV_DW'(1) : DIV_DW'(abs_s);
      side4_r <= '{px: p3_r.px, py: p3_r.py, s: p3_r.s, c: p3_r.c, cc: p3_r.cc,
                   rx0: rx0_3_r, ry0: ry0_3_r,
                   neg1: prod_v3_r[36] ^ p3_r.c[15],
                   neg3: prod_h3_r[36] ^ p3_r.s[15]};
    end
  end

  // --- intercept dividers ----------------------------------------------------
  logic [DIV_NW-1:0] q1, q2, q3, q4;

  grwc_div u_div_ry (.clk(clk), .en(en), .num(n1_r), .den(dc_r), .quot(q1));
  grwc_div u_div_yo (.clk(clk), .en(en), .num(n2_r), .den(dc_r), .quot(q2));
  grwc_div u_div_rx (.clk(clk), .en(en), .num(n3_r), .den(ds_r), .quot(q3));
  grwc_div u_div_xo (.clk(clk), .en(en), .num(n4_r), .den(ds_r), .quot(q4));

  side_t side_r [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side4_r;
      for (int i = 1; i < DIV_LAT; i++) side_r[i] <= side_r[i-1];
    end
  end

  // --- S5: march start points and steps --------------------------------------
  side_t              sd;
  logic signed [31:0] q1s, q2s, q3s, q4s;
  march_t             mv_r [0:MARCH_STEPS];
  march_t             mh_r [0:MARCH_STEPS];
  pos_t               mp_r [0:MARCH_STEPS];

  always_comb begin
    sd  = side_r[DIV_LAT-1];
    q1s = $signed({3'b000, q1});
    q2s = $signed({3'b000, q2});
    q3s = $signed({3'b000, q3});
    q4s = $signed({3'b000, q4});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mv_r[0].rx   <= sd.rx0;
      mv_r[0].ry   <= sat_coord($signed({15'd0, sd.py}) - (sd.neg1 ? -q1s : q1s));
      mv_r[0].xo   <= (sd.c > 0) ? 21'sd16384 : -21'sd16384;
      mv_r[0].yo   <= sat_coord((sd.s > 0) ? -q2s : q2s);
      mv_r[0].live <= (sd.c != 16'sd0);
      mv_r[0].hit  <= 1'b0;
      mh_r[0].rx   <= sat_coord($signed({15'd0, sd.px}) - (sd.neg3 ? -q3s : q3s));
      mh_r[0].ry   <= sd.ry0;
      mh_r[0].xo   <= sat_coord((sd.c > 0) ? q4s : -q4s);
      mh_r[0].yo   <= (sd.s > 0) ? -21'sd16384 : 21'sd16384;
      mh_r[0].live <= (sd.s != 16'sd0);
      mh_r[0].hit  <= 1'b0;
      mp_r[0]      <= '{px: sd.px, py: sd.py, s: sd.s, c: sd.c, cc: sd.cc};
    end
  end

  // --- march: one cell test per stage, both directions in parallel ----------
  function automatic march_t march_step(input march_t m, input logic [63:0] map);
    march_t r;
    logic   wall;
    r    = m;
    wall = m.live && is_wall(m.rx, m.ry, map);
    if (!m.hit && wall) begin
      r.hit = 1'b1;                 // freeze at the hit cell
    end else if (!m.hit) begin
      r.rx = sat_coord(32'(m.rx) + 32'(m.xo));
      r.ry = sat_coord(32'(m.ry) + 32'(m.yo));
    end
    return r;
  endfunction

  for (genvar k = 1; k <= MARCH_STEPS; k++) begin : g_march
    always_ff @(posedge clk) begin
      if (en) begin
        mv_r[k] <= march_step(mv_r[k-1], wall_map_r);
        mh_r[k] <= march_step(mh_r[k-1], wall_map_r);
        mp_r[k] <= mp_r[k-1];
      end
    end
  end

  // --- D1: distance products -------------------------------------------------
  march_t             mvf, mhf;
  pos_t               mpf;
  logic signed [21:0] dxv, dyv, dxh, dyh;
  logic signed [37:0] pvv_r, qvv_r, pvh_r, qvh_r;
  logic               hv1_r, hh1_r;
  logic [14:0]        cc_d1_r;

  always_comb begin
    mvf = mv_r[MARCH_STEPS];
    mhf = mh_r[MARCH_STEPS];
    mpf = mp_r[MARCH_STEPS];
    dxv = 22'(mvf.rx) - $signed({5'd0, mpf.px});
    dyv = 22'(mvf.ry) - $signed({5'd0, mpf.py});
    dxh = 22'(mhf.rx) - $signed({5'd0, mpf.px});
    dyh = 22'(mhf.ry) - $signed({5'd0, mpf.py});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pvv_r   <= 38'(mpf.c) * 38'(dxv);
      qvv_r   <= 38'(mpf.s) * 38'(dyv);
      pvh_r   <= 38'(mpf.c) * 38'(dxh);
      qvh_r   <= 38'(mpf.s) * 38'(dyh);
      hv1_r   <= mvf.hit;
      hh1_r   <= mhf.hit;
      cc_d1_r <= mpf.cc;
    end
  end

  // --- D2: distance along the ray, clamped at zero ---------------------------
  logic signed [38:0] ddv, ddh;
  logic [23:0]        distv_r, disth_r;
  logic               hv2_r, hh2_r;
  logic [14:0]        cc_d2_r;

  always_comb begin
    ddv = 39'(pvv_r) - 39'(qvv_r);
    ddh = 39'(pvh_r) - 39'(qvh_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // negative clamps to zero, so the shift needs no rounding fix
      distv_r <= ddv[38] ? 24'd0 : ddv[37:14];
      disth_r <= ddh[38] ? 24'd0 : ddh[37:14];
      hv2_r   <= hv1_r;
      hh2_r   <= hh1_r;
      cc_d2_r <= cc_d1_r;
    end
  end

  // --- D3: pick nearer hit, fisheye product ----------------------------------
  logic        use_v;
  logic [38:0] fprod3_r;
  logic        use_v3_r, found3_r;

  assign use_v = hv2_r && (!hh2_r || (distv_r < disth_r));  // tie goes horizontal

  always_ff @(posedge clk) begin
    if (en) begin
      fprod3_r <= 39'(use_v ? distv_r : disth_r) * 39'(cc_d2_r);
      use_v3_r <= use_v;
      found3_r <= hv2_r || hh2_r;
    end
  end

  // --- D4: corrected distance ------------------------------------------------
  logic [17:0] corr_nxt;
  fin_t        fin4_r;

  always_comb begin
    if (!found3_r)                      corr_nxt = 18'd0;
    else if (fprod3_r[38:32] != 7'd0)   corr_nxt = DIST_MAX;
    else                                corr_nxt = fprod3_r[31:14];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin4_r <= '{corr: corr_nxt, use_v: use_v3_r && found3_r, found: found3_r,
                  big: (corr_nxt <= FULL_LIMIT)};
    end
  end

  // --- height divider --------------------------------------------------------
  logic [DIV_NW-1:0] qh;
  logic [DIV_DW-1:0] hden;
  fin_t              fin_r [0:DIV_LAT-1];

  assign hden = (fin4_r.corr == 18'd0) ? DIV_DW'(1) : fin4_r.corr;

  grwc_div u_div_h (.clk(clk), .en(en), .num(HEIGHT_NUM), .den(hden), .quot(qh));

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r[0] <= fin4_r;
      for (int i = 1; i < DIV_LAT; i++) fin_r[i] <= fin_r[i-1];
    end
  end

  // --- F: output register ----------------------------------------------------
  fin_t       ff;
  logic [8:0] height;
  logic [8:0] height_r;
  logic [7:0] top_r;
  logic       hitv_r, found_r;
  logic [17:0] corr_r;

  always_comb begin
    ff = fin_r[DIV_LAT-1];
    if (!ff.found)   height = 9'd0;
    else if (ff.big) height = SCREEN_H;
    else             height = qh[8:0];     // corr above 16384 keeps it under 320
  end

  always_ff @(posedge clk) begin
    if (en) begin
      height_r <= height;
      top_r    <= SCREEN_MID - height[8:1];
      hitv_r   <= ff.use_v;
      found_r  <= ff.found;
      corr_r   <= ff.corr;
    end
  end

  assign out_ch.valid              = vld_r[PIPE_DEPTH-1];
  assign out_ch.wall_height        = height_r;
  assign out_ch.wall_top           = top_r;
  assign out_ch.hit_vertical       = hitv_r;
  assign out_ch.wall_found         = found_r;
  assign out_ch.corrected_distance = corr_r;

endmodule

`default_nettype wire

FILE: design/grwc_chk.sv
// ----------------------------------------------------------------------------
// grwc_chk: port-level checks for the column ray caster
// Watches the result channel for consistent slice fields, hold and reset.
// ----------------------------------------------------------------------------
`default_nettype none

module grwc_chk (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire [8:0]  wall_height,
  input wire [7:0]  wall_top,
  input wire        hit_vertical,
  input wire        wall_found,
  input wire [17:0] corrected_distance
);

  // no wall: empty slice
  a_no_wall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !wall_found |-> wall_height == 9'd0 && wall_top == 8'd160 &&
      corrected_distance == 18'd0 && !hit_vertical)
    else $error("empty slice fields wrong");

  // top is derived from height
  a_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && wall_found |-> wall_height <= 9'd320 &&
      wall_top == 8'd160 - wall_height[8:1])
    else $error("wall top does not match height");

  // close walls fill the screen
  a_near: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && wall_found && corrected_distance <= 18'd16384 |->
      wall_height == 9'd320)
    else $error("near wall not full height");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind grid_ray_wall_column grwc_chk u_grwc_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .wall_height        (out_ch.wall_height),
  .wall_top           (out_ch.wall_top),
  .hit_vertical       (out_ch.hit_vertical),
  .wall_found         (out_ch.wall_found),
  .corrected_distance (out_ch.corrected_distance)
);

`default_nettype wire
